[design/aie_pkg.sv]
// shared types and encoding constants for the integer alu execute block
package aie_pkg;

	// major opcode groups, taken from instruction bits 28..23 / 28..24 / 28..21
	localparam logic [5:0] GRP_ADD_IMM = 6'h22;
	localparam logic [5:0] GRP_LOG_IMM = 6'h24;
	localparam logic [5:0] GRP_MOV_WIDE = 6'h25;
	localparam logic [5:0] GRP_BITFIELD = 6'h26;
	localparam logic [5:0] GRP_EXTRACT = 6'h27;
	localparam logic [4:0] GRP_LOG_REG = 5'h0A;
	localparam logic [4:0] GRP_ADD_REG = 5'h0B;
	localparam logic [7:0] GRP_CARRY = 8'hD0;
	localparam logic [7:0] GRP_DATA_PROC = 8'hD6;

	// data-processing sub-opcodes (bits 15..10)
	localparam logic [5:0] DP2_UDIV = 6'b000010;
	localparam logic [5:0] DP2_SDIV = 6'b000011;
	localparam logic [3:0] DP2_SHIFT = 4'b0010;
	localparam logic [5:0] DP1_RBIT = 6'b000000;
	localparam logic [5:0] DP1_REV16 = 6'b000001;
	localparam logic [5:0] DP1_REV32 = 6'b000010;
	localparam logic [5:0] DP1_REV64 = 6'b000011;
	localparam logic [5:0] DP1_CLZ = 6'b000100;
	localparam logic [5:0] DP1_CLS = 6'b000101;

	// logical opc values
	localparam logic [1:0] LOP_AND = 2'd0;
	localparam logic [1:0] LOP_ORR = 2'd1;
	localparam logic [1:0] LOP_EOR = 2'd2;
	localparam logic [1:0] LOP_ANDS = 2'd3;

	// move wide opc values
	localparam logic [1:0] MOV_N = 2'd0;
	localparam logic [1:0] MOV_Z = 2'd2;
	localparam logic [1:0] MOV_K = 2'd3;

	// bitfield opc values
	localparam logic [1:0] BF_SBFM = 2'd0;
	localparam logic [1:0] BF_BFM = 2'd1;

	// shift types
	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	localparam logic [4:0] ZERO_REG = 5'd31;

	typedef enum logic {
		ITER_DIV,
		ITER_CNT
	} iter_mode_t;

	// controller to datapath
	typedef struct packed {
		logic ld_instr;
		logic rd_a;
		logic rd_b;
		logic prep;
		logic iter_start;
		logic exec;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_iter;
		logic iter_done;
		logic out_free;
	} sts_t;

endpackage

[design/aie_iter.sv]
// iterative unit: restoring divider and leading-bit counter, one bit per cycle
module aie_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  aie_pkg::iter_mode_t mode,
	input  logic [63:0]         dividend,
	input  logic [63:0]         divisor,
	input  logic [64:0]         scan,
	output logic                busy,
	output logic [63:0]         quotient,
	output logic [6:0]          count
);

	logic               busy_q;
	aie_pkg::iter_mode_t mode_q;
	logic [5:0]         cnt_q;
	logic [63:0]        rem_q;
	logic [63:0]        quo_q;
	logic [63:0]        div_q;
	logic [64:0]        scan_q;
	logic [6:0]         lz_q;
	logic [64:0]        trial;
	logic [64:0]        diff;
	logic               fits;

	// one restoring step
	always_comb begin
		trial = {rem_q, quo_q[63]};
		diff = trial - {1'b0, div_q};
		fits = trial >= {1'b0, div_q};
	end

	// busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (mode_q == aie_pkg::ITER_DIV) begin
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end else if (scan_q[64]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
			scan_q <= scan;
			lz_q <= '0;
		end else if (busy_q) begin
			if (mode_q == aie_pkg::ITER_DIV) begin
				cnt_q <= cnt_q + 6'd1;
				rem_q <= fits ? diff[63:0] : trial[63:0];
				quo_q <= {quo_q[62:0], fits};
			end else if (!scan_q[64]) begin
				scan_q <= {scan_q[63:0], 1'b0};
				lz_q <= lz_q + 7'd1;
			end
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
	assign count = lz_q;

endmodule

[design/aie_ctrl.sv]
// sequencing state machine for the execute block
module aie_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  aie_pkg::sts_t sts,
	output aie_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RDA  = 7'b0000010,
		S_RDB  = 7'b0000100,
		S_PREP = 7'b0001000,
		S_ITER = 7'b0010000,
		S_EXEC = 7'b0100000,
		S_WB   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nx;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_instr = 1'b1;
					state_nx = S_RDA;
				end
			end
			S_RDA: begin
				cmd.rd_a = 1'b1;
				state_nx = S_RDB;
			end
			S_RDB: begin
				cmd.rd_b = 1'b1;
				state_nx = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (sts.is_iter) begin
					cmd.iter_start = 1'b1;
					state_nx = S_ITER;
				end else begin
					state_nx = S_EXEC;
				end
			end
			S_ITER: begin
				if (sts.iter_done) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = S_WB;
			end
			S_WB: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

[design/aie_dp.sv]
// datapath: register file, flags, decode, operand prep, alu and result register
module aie_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  aie_pkg::cmd_t cmd,
	output aie_pkg::sts_t sts,
	input  logic [31:0]   instruction_word,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          dest_valid,
	output logic [4:0]    dest_index,
	output logic [63:0]   dest_value,
	output logic          flags_valid,
	output logic [3:0]    flags_value,
	output logic          illegal
);

	typedef enum logic [2:0] {
		K_ADD,
		K_LOG,
		K_BFM,
		K_PRE,
		K_DIV,
		K_CNT
	} kind_t;

	// shift of a ds-wide value, amount taken modulo ds
	function automatic logic [63:0] shv(input logic [63:0] x, input logic [1:0] ty,
			input logic [5:0] amt, input logic sf);
		logic [63:0] m;
		logic [63:0] xm;
		logic [63:0] r;
		logic [5:0] n;
		logic [127:0] dbl;
		logic signed [63:0] sx;
		m = sf ? {64{1'b1}} : {32'd0, {32{1'b1}}};
		xm = x & m;
		n = sf ? amt : {1'b0, amt[4:0]};
		sx = sf ? xm : {{32{xm[31]}}, xm[31:0]};
		dbl = sf ? {xm, xm} : {64'd0, xm[31:0], xm[31:0]};
		case (ty)
			aie_pkg::SH_LSL: r = (xm << n) & m;
			aie_pkg::SH_LSR: r = xm >> n;
			aie_pkg::SH_ASR: r = 64'(sx >>> n) & m;
			aie_pkg::SH_ROR: r = 64'(dbl >> n) & m;
			default: r = xm;
		endcase
		return r;
	endfunction

	// register file and its valid bits
	logic [63:0] mem [32];
	logic [31:0] vld_q;

	logic [31:0] instr_q;
	logic [63:0] a_mem_q, b_mem_q, d_mem_q;
	logic        a_ok_q, b_ok_q, d_ok_q;
	logic [3:0]  flags_q;

	// prepared operands
	kind_t       kind_q;
	logic        ok_q, setf_q, cin_q, top_q, neg_q, dz_q;
	logic [63:0] add_b_q, log_b_q, pre_q, bot_q, wm_q, tm_q;

	// result
	logic [63:0] res_q;
	logic [3:0]  nf_q;

	// output register
	logic        out_valid_q;
	logic        o_dv_q, o_fv_q, o_ill_q;
	logic [4:0]  o_idx_q;
	logic [63:0] o_val_q;
	logic [3:0]  o_fl_q;

	// instruction fields
	logic        sf;
	logic [1:0]  opc;
	logic [4:0]  rd, rn, rm;
	logic [5:0]  imms, immr;
	logic [63:0] m, am, bm, dm;

	always_comb begin
		sf = instr_q[31];
		opc = instr_q[30:29];
		rd = instr_q[4:0];
		rn = instr_q[9:5];
		rm = instr_q[20:16];
		imms = instr_q[15:10];
		immr = instr_q[21:16];
		m = sf ? {64{1'b1}} : {32'd0, {32{1'b1}}};
		am = (a_ok_q ? a_mem_q : 64'd0) & m;
		bm = (b_ok_q ? b_mem_q : 64'd0) & m;
		dm = (d_ok_q ? d_mem_q : 64'd0) & m;
	end

	// bit mask decode
	logic [6:0]  bmv;
	logic [2:0]  blen;
	logic        blen_hit;
	logic [5:0]  lv, bs, br, bd, be;
	logic [63:0] wpat, wmask, tmask;
	logic [127:0] wdbl;
	logic        bm_ok, bm_rsv;

	always_comb begin
		bmv = {instr_q[22], ~imms};
		blen = 3'd0;
		blen_hit = 1'b0;
		for (int k = 6; k >= 0; k--) begin
			if (!blen_hit && bmv[k]) begin
				blen = 3'(k);
				blen_hit = 1'b1;
			end
		end
		lv = 6'((7'd1 << blen) - 7'd1);
		bs = imms & lv;
		br = immr & lv;
		bd = (bs - br) & lv;
		for (int i = 0; i < 64; i++) begin
			be = 6'(i) & lv;
			wpat[i] = be <= bs;
			tmask[i] = be <= bd;
		end
		wdbl = {wpat, wpat} >> br;
		wmask = wdbl[63:0];
		bm_ok = blen_hit && (blen != 3'd0) && !(blen == 3'd6 && !sf);
		bm_rsv = bs == lv;
	end

	// decode and operand preparation
	kind_t       kind_c;
	logic        ok_c, setf_c, cin_c, top_c, neg_c, dz_c, is_iter_c;
	logic [63:0] add_b_c, log_b_c, pre_c, bot_c, imm_c, o2_c, ua_c, ub_c;
	logic [64:0] scan_c;
	logic [62:0] y63;
	logic [30:0] y31;
	logic [2:0]  rx;
	logic [2:0]  src;
	logic [127:0] xdbl;
	logic [5:0]  pos;
	aie_pkg::iter_mode_t mode_c;

	always_comb begin
		kind_c = K_PRE;
		ok_c = 1'b0;
		setf_c = 1'b0;
		cin_c = 1'b0;
		top_c = am[imms];
		neg_c = 1'b0;
		dz_c = 1'b0;
		add_b_c = '0;
		log_b_c = '0;
		pre_c = '0;
		bot_c = shv(am, aie_pkg::SH_ROR, immr, sf) & wmask;
		imm_c = '0;
		o2_c = shv(bm, instr_q[23:22], imms, sf);
		ua_c = am;
		ub_c = bm;
		mode_c = aie_pkg::ITER_DIV;
		y63 = am[62:0] ^ am[63:1];
		y31 = am[30:0] ^ am[31:1];
		scan_c = {am, 1'b1};
		rx = 3'd0;
		src = 3'd0;
		xdbl = '0;
		pos = {instr_q[22:21], 4'd0};
		if (instr_q[28:23] == aie_pkg::GRP_ADD_IMM) begin
			imm_c = {52'd0, instr_q[21:10]} << (instr_q[22] ? 6'd12 : 6'd0);
			ok_c = 1'b1;
			kind_c = K_ADD;
			add_b_c = (instr_q[30] ? ~imm_c : imm_c) & m;
			cin_c = instr_q[30];
			setf_c = instr_q[29];
		end else if (instr_q[28:23] == aie_pkg::GRP_LOG_IMM) begin
			ok_c = !(!sf && instr_q[22]) && bm_ok && !bm_rsv;
			kind_c = K_LOG;
			log_b_c = wmask & m;
			setf_c = opc == aie_pkg::LOP_ANDS;
		end else if (instr_q[28:23] == aie_pkg::GRP_MOV_WIDE) begin
			ok_c = !(opc == 2'd1 || (!sf && instr_q[22]));
			imm_c = {48'd0, instr_q[20:5]} << pos;
			case (opc)
				aie_pkg::MOV_N: pre_c = ~imm_c & m;
				aie_pkg::MOV_Z: pre_c = imm_c;
				aie_pkg::MOV_K: pre_c = ((dm & ~(64'hFFFF << pos)) | imm_c) & m;
				default: pre_c = '0;
			endcase
		end else if (instr_q[28:23] == aie_pkg::GRP_BITFIELD) begin
			ok_c = opc != 2'd3 && instr_q[22] == sf && !(!sf && (immr[5] | imms[5])) &&
				bm_ok;
			kind_c = K_BFM;
		end else if (instr_q[28:23] == aie_pkg::GRP_EXTRACT) begin
			ok_c = opc == 2'd0 && !instr_q[21] && instr_q[22] == sf && !(!sf && imms[5]);
			xdbl = (sf ? {am, bm} : {64'd0, am[31:0], bm[31:0]}) >> imms;
			pre_c = xdbl[63:0] & m;
		end else if (instr_q[28:24] == aie_pkg::GRP_LOG_REG) begin
			ok_c = !(!sf && imms[5]);
			kind_c = K_LOG;
			log_b_c = instr_q[21] ? (~o2_c & m) : o2_c;
			setf_c = opc == aie_pkg::LOP_ANDS;
		end else if (instr_q[28:24] == aie_pkg::GRP_ADD_REG && !instr_q[21]) begin
			ok_c = instr_q[23:22] != 2'd3 && !(!sf && imms[5]);
			kind_c = K_ADD;
			add_b_c = instr_q[30] ? (~o2_c & m) : o2_c;
			cin_c = instr_q[30];
			setf_c = instr_q[29];
		end else if (instr_q[28:21] == aie_pkg::GRP_CARRY && imms == 6'd0) begin
			ok_c = 1'b1;
			kind_c = K_ADD;
			add_b_c = instr_q[30] ? (~bm & m) : bm;
			cin_c = flags_q[1];
			setf_c = instr_q[29];
		end else if (instr_q[28:21] == aie_pkg::GRP_DATA_PROC && !instr_q[29]) begin
			if (!instr_q[30]) begin
				if (imms == aie_pkg::DP2_UDIV) begin
					ok_c = 1'b1;
					kind_c = K_DIV;
					dz_c = bm == 64'd0;
				end else if (imms == aie_pkg::DP2_SDIV) begin
					ok_c = 1'b1;
					kind_c = K_DIV;
					dz_c = bm == 64'd0;
					ua_c = (sf ? am[63] : am[31]) ? ((64'd0 - am) & m) : am;
					ub_c = (sf ? bm[63] : bm[31]) ? ((64'd0 - bm) & m) : bm;
					neg_c = (sf ? am[63] : am[31]) ^ (sf ? bm[63] : bm[31]);
				end else if (imms[5:2] == aie_pkg::DP2_SHIFT) begin
					ok_c = 1'b1;
					pre_c = shv(am, imms[1:0], bm[5:0], sf);
				end
			end else if (rm == 5'd0) begin
				if (imms == aie_pkg::DP1_RBIT) begin
					ok_c = 1'b1;
					for (int i = 0; i < 64; i++) begin
						pre_c[i] = sf ? am[63 - i] : ((i < 32) ? am[31 - i] : 1'b0);
					end
				end else if (imms == aie_pkg::DP1_REV16 || imms == aie_pkg::DP1_REV32 ||
						imms == aie_pkg::DP1_REV64) begin
					ok_c = !(imms == aie_pkg::DP1_REV64 && !sf);
					rx = (imms == aie_pkg::DP1_REV16) ? 3'd1 :
						((imms == aie_pkg::DP1_REV32) ? 3'd3 : 3'd7);
					for (int j = 0; j < 8; j++) begin
						src = 3'(j) ^ rx;
						pre_c[8 * j +: 8] = am[8 * src +: 8];
					end
				end else if (imms == aie_pkg::DP1_CLZ || imms == aie_pkg::DP1_CLS) begin
					ok_c = 1'b1;
					kind_c = K_CNT;
					mode_c = aie_pkg::ITER_CNT;
					if (imms == aie_pkg::DP1_CLZ) begin
						scan_c = sf ? {am, 1'b1} : {am[31:0], 1'b1, 32'd0};
					end else begin
						scan_c = sf ? {y63, 1'b1, 1'b0} : {y31, 1'b1, 33'd0};
					end
				end
			end
		end
		is_iter_c = ok_c && (kind_c == K_DIV || kind_c == K_CNT);
	end

	// iterative unit
	logic        it_busy;
	logic [63:0] it_quo;
	logic [6:0]  it_cnt;

	aie_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.iter_start),
		.mode     (mode_c),
		.dividend (ua_c),
		.divisor  (ub_c),
		.scan     (scan_c),
		.busy     (it_busy),
		.quotient (it_quo),
		.count    (it_cnt)
	);

	// alu
	logic [64:0] sum;
	logic [63:0] res_c, lg, bot2;
	logic [3:0]  nf_c;
	logic        cy;

	always_comb begin
		sum = {1'b0, am} + {1'b0, add_b_q} + {64'd0, cin_q};
		cy = sf ? sum[64] : sum[32];
		case (opc)
			aie_pkg::LOP_ORR: lg = am | log_b_q;
			aie_pkg::LOP_EOR: lg = am ^ log_b_q;
			default: lg = am & log_b_q;
		endcase
		bot2 = (dm & ~wm_q) | bot_q;
		res_c = '0;
		case (kind_q)
			K_ADD: res_c = sum[63:0] & m;
			K_LOG: res_c = lg;
			K_BFM: begin
				case (opc)
					aie_pkg::BF_SBFM: res_c = ((top_q ? ~tm_q : 64'd0) | (bot_q & tm_q)) & m;
					aie_pkg::BF_BFM: res_c = ((dm & ~tm_q) | (bot2 & tm_q)) & m;
					default: res_c = bot_q & tm_q;
				endcase
			end
			K_PRE: res_c = pre_q;
			K_DIV: res_c = dz_q ? 64'd0 : ((neg_q ? (64'd0 - it_quo) : it_quo) & m);
			K_CNT: res_c = {57'd0, it_cnt};
			default: res_c = '0;
		endcase
		if (kind_q == K_ADD) begin
			nf_c = {sf ? res_c[63] : res_c[31], res_c == 64'd0, cy,
				sf ? ((~(am[63] ^ add_b_q[63])) & (am[63] ^ res_c[63]))
				   : ((~(am[31] ^ add_b_q[31])) & (am[31] ^ res_c[31]))};
		end else begin
			nf_c = {sf ? res_c[63] : res_c[31], res_c == 64'd0, 2'b00};
		end
	end

	// instruction latch, register file reads and write, preparation and result registers
	always_ff @(posedge clk) begin
		if (cmd.ld_instr) begin
			instr_q <= instruction_word;
		end
		if (cmd.rd_a) begin
			a_mem_q <= mem[rn];
			b_mem_q <= mem[rm];
		end
		if (cmd.rd_b) begin
			d_mem_q <= mem[rd];
		end
		if (cmd.prep) begin
			kind_q <= kind_c;
			ok_q <= ok_c;
			setf_q <= setf_c;
			cin_q <= cin_c;
			top_q <= top_c;
			neg_q <= neg_c;
			dz_q <= dz_c;
			add_b_q <= add_b_c;
			log_b_q <= log_b_c;
			pre_q <= pre_c;
			bot_q <= bot_c;
			wm_q <= wmask;
			tm_q <= tmask;
		end
		if (cmd.exec) begin
			res_q <= res_c;
			nf_q <= nf_c;
		end
		if (cmd.commit && ok_q && rd != aie_pkg::ZERO_REG) begin
			mem[rd] <= res_q;
		end
	end

	// valid bits of register reads (zero register and never-written entries read zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			a_ok_q <= 1'b0;
			b_ok_q <= 1'b0;
			d_ok_q <= 1'b0;
		end else begin
			if (cmd.rd_a) begin
				a_ok_q <= vld_q[rn] && rn != aie_pkg::ZERO_REG;
				b_ok_q <= vld_q[rm] && rm != aie_pkg::ZERO_REG;
			end
			if (cmd.rd_b) begin
				d_ok_q <= vld_q[rd] && rd != aie_pkg::ZERO_REG;
			end
			if (cmd.commit && ok_q && rd != aie_pkg::ZERO_REG) begin
				vld_q[rd] <= 1'b1;
			end
		end
	end

	// condition flags and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && ok_q && setf_q) begin
				flags_q <= nf_q;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			o_dv_q <= ok_q && rd != aie_pkg::ZERO_REG;
			o_idx_q <= (ok_q && rd != aie_pkg::ZERO_REG) ? rd : 5'd0;
			o_val_q <= (ok_q && rd != aie_pkg::ZERO_REG) ? res_q : 64'd0;
			o_fv_q <= ok_q && setf_q;
			o_fl_q <= (ok_q && setf_q) ? nf_q : flags_q;
			o_ill_q <= !ok_q;
		end
	end

	// status
	always_comb begin
		sts.is_iter = is_iter_c;
		sts.iter_done = !it_busy;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign dest_valid = o_dv_q;
	assign dest_index = o_idx_q;
	assign dest_value = o_val_q;
	assign flags_valid = o_fv_q;
	assign flags_value = o_fl_q;
	assign illegal = o_ill_q;

endmodule

[design/aarch64_integer_alu_execute.sv]
// top level of the integer alu execute block
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | instruction_word
//  out     | output    | out_valid/out_ready | dest_valid, dest_index, dest_value,
//          |           |                     | flags_valid, flags_value, illegal
//
// one instruction at a time: transfer, two register file read steps, operand prep,
// alu, then write-back into the output register.
// udiv/sdiv run in the bit-serial divider, clz/cls in the bit scanner.
// reset clears the flags, the register valid bits and the controller; no clearing pass.
// a full output register holds write-back until the waiting result transfers.
module aarch64_integer_alu_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        dest_valid,
	output logic [4:0]  dest_index,
	output logic [63:0] dest_value,
	output logic        flags_valid,
	output logic [3:0]  flags_value,
	output logic        illegal
);

	aie_pkg::cmd_t cmd;
	aie_pkg::sts_t sts;

	aie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	aie_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.instruction_word (instruction_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.dest_valid       (dest_valid),
		.dest_index       (dest_index),
		.dest_value       (dest_value),
		.flags_valid      (flags_valid),
		.flags_value      (flags_value),
		.illegal          (illegal)
	);

endmodule
